@@ hdl/ffba_pkg.sv @@
package ffba_pkg;

   // Table geometry and block layout.
   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 16;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

   // Field widths and the extended width used for end-of-block arithmetic.
   localparam int WORD_W = 32;
   localparam int EXT_W  = WORD_W + 2;

   // Configuration port geometry and register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_HEAP_BASE = 1'b0;
   localparam logic REG_HEAP_END  = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [WORD_W-1:0] HEAP_BASE_RESET = '0;
   localparam logic [WORD_W-1:0] HEAP_END_RESET  = '1;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NULL     = 2'd1;
   localparam logic [1:0] STAT_NOSPACE  = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   // One row of the block table.
   typedef struct packed {
      logic              in_use;
      logic [WORD_W-1:0] size;
      logic [WORD_W-1:0] data_addr;
   } entry_type;

endpackage

@@ hdl/first_fit_block_allocator_core.sv @@
// First-fit block allocator. Start a transaction by raising start while busy is low; busy
// is low in the cycle in which the result is shown. Every transaction gives exactly one
// result, shown for a single cycle with rsp_strobe, and the receiver cannot hold it off, so
// it must take the result in that cycle. A null request (an allocate of size zero or a free
// of address zero), or a free on an empty table, answers in the cycle after acceptance, and
// an allocate on an empty table goes straight to the append step and answers from there.
// Otherwise the block table is scanned through its single read port, one entry per cycle:
// a free or a fitting allocate answers at the first hit, a free that misses answers not
// found after the last live entry, and an allocate with no fit goes to the append step.
// The table memory holds no reset values; only entries below the block count are ever read.
// Write heap_base and heap_end only while idle.
module first_fit_block_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [ffba_pkg::WORD_W-1:0]       req_request_size,
   input  logic [ffba_pkg::WORD_W-1:0]       req_release_address,
   output logic                              rsp_strobe,
   output logic [ffba_pkg::WORD_W-1:0]       rsp_granted_address,
   output logic [1:0]                        rsp_status,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import ffba_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_APPEND = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic              op_ff;
   logic [WORD_W-1:0] size_ff;
   logic [WORD_W-1:0] release_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [WORD_W-1:0] top_ff;
   logic [WORD_W-1:0] top_in;
   logic [CNT_W-1:0]  issue_ff;
   logic [CNT_W-1:0]  issue_in;
   logic              chk_valid_ff;
   logic [IDX_W-1:0]  chk_idx_ff;
   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;
   logic [WORD_W-1:0] rsp_addr_ff;
   logic [WORD_W-1:0] rsp_addr_in;
   logic [1:0]        rsp_status_ff;
   logic [1:0]        rsp_status_in;

   logic [WORD_W-1:0] heap_base;
   logic [WORD_W-1:0] heap_end;

   logic              accept;
   logic              rd_en;
   entry_type         rd_entry;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_entry;

   logic              fit;
   logic              match;
   logic              hit;
   logic              last;
   logic [WORD_W-1:0] hdr_addr;
   logic [EXT_W-1:0]  data_ext;
   logic [EXT_W-1:0]  end_ext;
   logic              full;
   logic              over;

   // Configuration registers.
   ffba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .heap_base (heap_base),
      .heap_end  (heap_end)
   );

   // Block table memory.
   ffba_table u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_idx   (issue_ff[IDX_W-1:0]),
      .rd_entry (rd_entry)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // One table read is issued per scan cycle until every live entry is covered.
   assign rd_en = (state_ff == S_SCAN) && (issue_ff < count_ff);

   // Checks on the entry that came back from the memory this cycle.
   assign fit   = !rd_entry.in_use && (rd_entry.size >= size_ff);
   assign match = (rd_entry.data_addr == release_ff);
   assign hit   = chk_valid_ff && ((op_ff == OP_ALLOC) ? fit : match);
   assign last  = chk_valid_ff
                  && ((CNT_W'({1'b0, chk_idx_ff}) + CNT_W'(1)) == count_ff);

   // Placement of an appended block, computed wide so that it cannot wrap.
   assign hdr_addr = (count_ff == '0) ? heap_base : top_ff;
   assign data_ext = EXT_W'(hdr_addr) + EXT_W'(HEADER_BYTES);
   assign end_ext  = data_ext + EXT_W'(size_ff);
   assign full     = (count_ff == CNT_W'(MAX_BLOCKS));
   assign over     = (end_ext > EXT_W'(heap_end));

   // Sequencer: accept, scan the table, append if needed, and post the result.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      top_in         = top_ff;
      issue_in       = rd_en ? (issue_ff + CNT_W'(1)) : issue_ff;
      wr_en          = 1'b0;
      wr_idx         = chk_idx_ff;
      wr_entry       = rd_entry;
      rsp_strobe_in  = 1'b0;
      rsp_addr_in    = '0;
      rsp_status_in  = STAT_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               issue_in = '0;
               if (((req_opcode == OP_ALLOC) && (req_request_size == '0))
                   || ((req_opcode == OP_FREE) && (req_release_address == '0))) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_NULL;
               end else if (count_ff == '0) begin
                  if (req_opcode == OP_ALLOC) begin
                     state_in = S_APPEND;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STAT_NOTFOUND;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (hit) begin
               // Write back the matching entry with its new used flag.
               wr_en           = 1'b1;
               wr_entry.in_use = (op_ff == OP_ALLOC);
               rsp_strobe_in   = 1'b1;
               rsp_status_in   = STAT_OK;
               rsp_addr_in     = (op_ff == OP_ALLOC) ? rd_entry.data_addr : '0;
               state_in        = S_IDLE;
            end else if (last) begin
               if (op_ff == OP_ALLOC) begin
                  state_in = S_APPEND;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_NOTFOUND;
                  state_in      = S_IDLE;
               end
            end
         end

         S_APPEND: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (full || over) begin
               rsp_status_in = STAT_NOSPACE;
            end else begin
               wr_en              = 1'b1;
               wr_idx             = count_ff[IDX_W-1:0];
               wr_entry.in_use    = 1'b1;
               wr_entry.size      = size_ff;
               wr_entry.data_addr = data_ext[WORD_W-1:0];
               count_in           = count_ff + CNT_W'(1);
               top_in             = end_ext[WORD_W-1:0];
               rsp_status_in      = STAT_OK;
               rsp_addr_in        = data_ext[WORD_W-1:0];
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         top_ff        <= '0;
         issue_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         top_ff        <= top_in;
         issue_ff      <= issue_in;
         chk_valid_ff  <= rd_en;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Transaction payload, the index of the entry in flight, and the result.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_opcode;
         size_ff    <= req_request_size;
         release_ff <= req_release_address;
      end
      chk_idx_ff    <= issue_ff[IDX_W-1:0];
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

@@ hdl/ffba_csr.sv @@
module ffba_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output logic [ffba_pkg::WORD_W-1:0]       heap_base,
   output logic [ffba_pkg::WORD_W-1:0]       heap_end
);
   import ffba_pkg::*;

   logic              reg_sel;
   logic              wr_fire;
   logic [WORD_W-1:0] heap_base_ff;
   logic [WORD_W-1:0] heap_end_ff;

   // Registers are selected by the word index; the byte offset is ignored.
   assign reg_sel = paddr[CSR_ADDR_W-1];
   assign wr_fire = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= HEAP_BASE_RESET;
         heap_end_ff  <= HEAP_END_RESET;
      end else if (wr_fire) begin
         case (reg_sel)
            REG_HEAP_BASE: heap_base_ff <= pwdata;
            REG_HEAP_END:  heap_end_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   // Read data follows the address with no wait states.
   always_comb begin
      case (reg_sel)
         REG_HEAP_BASE: prdata = heap_base_ff;
         REG_HEAP_END:  prdata = heap_end_ff;
         default:       prdata = '0;
      endcase
   end

   assign heap_base = heap_base_ff;
   assign heap_end  = heap_end_ff;

endmodule

@@ hdl/ffba_table.sv @@
module ffba_table (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ffba_pkg::IDX_W-1:0]   wr_idx,
   input  ffba_pkg::entry_type          wr_entry,
   input  logic                         rd_en,
   input  logic [ffba_pkg::IDX_W-1:0]   rd_idx,
   output ffba_pkg::entry_type          rd_entry
);
   import ffba_pkg::*;

   entry_type entry_mem [MAX_BLOCKS];
   entry_type rd_entry_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_entry;
      end
   end

   // Single read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule
